// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the wheel velocity controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a clocked property, skipped while reset is asserted.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property check failed");

// Check that a condition never holds at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== rtl/dwvpid_pkg.sv =====
// Package of the dual wheel velocity PID: widths, register indexes, divider step.
package dwvpid_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_GAIN_P  = 3'd0;
    localparam logic [2:0] CFG_GAIN_I  = 3'd1;
    localparam logic [2:0] CFG_GAIN_D  = 3'd2;
    localparam logic [2:0] CFG_DIVISOR = 3'd3;
    localparam logic [2:0] CFG_MAX_PWM = 3'd4;

    // Register reset values
    localparam logic [15:0] GAIN_P_RST  = 16'd5120;
    localparam logic [15:0] GAIN_I_RST  = 16'd0;
    localparam logic [15:0] GAIN_D_RST  = 16'd3072;
    localparam logic [15:0] DIVISOR_RST = 16'd50;
    localparam logic [14:0] MAX_PWM_RST = 15'd255;

    // Datapath widths
    localparam int ERR_W   = 33;  // target - speed, speed - last speed
    localparam int PROD_W  = 50;  // 17 bit gain times 33 bit operand
    localparam int ACC_W   = 52;  // summed PID numerator
    localparam int INTEG_W = 48;  // integral store
    localparam int QUO_W   = 44;  // |numerator| >> 8

    // Divider: two quotient bits per cycle
    localparam int DIV_STEPS = QUO_W / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // One restoring division step: returns {quotient bit, new remainder}.
    function automatic logic [16:0] div_step(input logic [15:0] rem,
                                             input logic        bit_in,
                                             input logic [15:0] dvs);
        logic [16:0] t;
        logic [16:0] diff;
        t    = {rem, bit_in};
        diff = t - {1'b0, dvs};
        if (t >= {1'b0, dvs})
            return {1'b1, diff[15:0]};
        else
            return {1'b0, t[15:0]};
    endfunction

endpackage

// ===== rtl/dual_wheel_velocity_pid.sv =====
// Dual wheel velocity PID: sequencer with a shared multiplier and a radix-4 divider.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid, in_ready, encoder_*, target_*, moving  | into block
//   out     | out_valid, out_ready, drive_left, drive_right    | out of block
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data        | into block
//
// Per wheel, a moving beat runs speed, error, three shared 17x33 multiplier passes,
// divider load, 22 radix-4 divider steps, drive sum and clamp, right wheel first,
// then loads the output register. An idle beat gives no result. in_ready is high
// only while the sequencer is idle; a finished result waits in its output register
// until taken, and a next one holds the sequencer in its done state. Reset loads
// control, config and per-wheel state, not the payload registers; no clearing pass.
`include "assert_macros.svh"

module dual_wheel_velocity_pid
    import dwvpid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input items
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] encoder_left,
    input  logic signed [31:0] encoder_right,
    input  logic signed [15:0] target_left,
    input  logic signed [15:0] target_right,
    input  logic               moving,
    // result items
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] drive_left,
    output logic signed [15:0] drive_right,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIFF  = 4'd1;
    localparam logic [3:0] ST_ERR   = 4'd2;
    localparam logic [3:0] ST_MULP  = 4'd3;
    localparam logic [3:0] ST_MULD  = 4'd4;
    localparam logic [3:0] ST_MULI  = 4'd5;
    localparam logic [3:0] ST_DINIT = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_ADD   = 4'd8;
    localparam logic [3:0] ST_CLAMP = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    // Configuration registers
    logic [15:0] gain_p_reg, gain_i_reg, gain_d_reg, divisor_reg;
    logic [14:0] max_pwm_reg;

    // Sequencer control
    logic [3:0]        state_reg, state_next;
    logic              ch_reg, ch_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              out_valid_reg, out_valid_next;

    // Captured input beat
    logic [31:0]        enc_reg [2];
    logic [31:0]        enc_next [2];
    logic signed [15:0] tgt_reg [2];
    logic signed [15:0] tgt_next [2];

    // Per-wheel controller state (index 0 left, 1 right)
    logic [31:0]               last_count_reg [2];
    logic [31:0]               last_count_next [2];
    logic signed [31:0]        last_speed_reg [2];
    logic signed [31:0]        last_speed_next [2];
    logic signed [15:0]        last_drive_reg [2];
    logic signed [15:0]        last_drive_next [2];
    logic signed [INTEG_W-1:0] integ_reg [2];
    logic signed [INTEG_W-1:0] integ_next [2];

    // Working registers
    logic signed [31:0]       speed_reg, speed_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [ERR_W-1:0]  dsp_reg, dsp_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     neg_reg, neg_next;
    logic [QUO_W-1:0]         dq_reg, dq_next;
    logic [15:0]              rem_reg, rem_next;
    logic [15:0]              dvs_reg, dvs_next;

    // Output registers
    logic signed [15:0] drive_left_reg, drive_left_next;
    logic signed [15:0] drive_right_reg, drive_right_next;

    // Shared multiplier
    logic [15:0]              mul_a;
    logic signed [ERR_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_res;

    // Scratch values of the sequencer
    logic               in_acc;
    logic [16:0]        step_hi, step_lo;
    logic [ACC_W-1:0]   mag;
    logic signed [ACC_W-1:0] qext, qsig, lim_pos, lim_neg;
    logic signed [INTEG_W+2:0] isum;
    logic signed [15:0] drive_val;
    logic               clamped;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid   = out_valid_reg;
    assign drive_left  = drive_left_reg;
    assign drive_right = drive_right_reg;

    // Pick multiplier operands by step
    always_comb
    begin
        case (state_reg)
            ST_MULP:
            begin
                mul_a = gain_p_reg;
                mul_b = err_reg;
            end
            ST_MULD:
            begin
                mul_a = gain_d_reg;
                mul_b = dsp_reg;
            end
            default:
            begin
                mul_a = gain_i_reg;
                mul_b = err_reg;
            end
        endcase
    end

    assign mul_res = $signed({1'b0, mul_a}) * mul_b;

    // Sequencer and datapath next state
    always_comb
    begin
        state_next       = state_reg;
        ch_next          = ch_reg;
        dcnt_next        = dcnt_reg;
        out_valid_next   = out_valid_reg;
        enc_next         = enc_reg;
        tgt_next         = tgt_reg;
        last_count_next  = last_count_reg;
        last_speed_next  = last_speed_reg;
        last_drive_next  = last_drive_reg;
        integ_next       = integ_reg;
        speed_next       = speed_reg;
        err_next         = err_reg;
        dsp_next         = dsp_reg;
        prod_next        = prod_reg;
        acc_next         = acc_reg;
        neg_next         = neg_reg;
        dq_next          = dq_reg;
        rem_next         = rem_reg;
        dvs_next         = dvs_reg;
        drive_left_next  = drive_left_reg;
        drive_right_next = drive_right_reg;

        step_hi   = div_step(rem_reg, dq_reg[QUO_W-1], dvs_reg);
        step_lo   = div_step(step_hi[15:0], dq_reg[QUO_W-2], dvs_reg);
        mag       = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        qext      = $signed({{(ACC_W-QUO_W){1'b0}}, dq_reg});
        qsig      = neg_reg ? -qext : qext;
        lim_pos   = $signed({{(ACC_W-15){1'b0}}, max_pwm_reg});
        lim_neg   = -lim_pos;
        isum      = $signed({{3{integ_reg[ch_reg][INTEG_W-1]}}, integ_reg[ch_reg]})
                  + $signed({prod_reg[PROD_W-1], prod_reg});
        clamped   = 1'b1;
        drive_val = acc_reg[15:0];
        if (acc_reg >= lim_pos)
            drive_val = lim_pos[15:0];
        else if (acc_reg <= lim_neg)
            drive_val = lim_neg[15:0];
        else
            clamped = 1'b0;

        // Drop the result beat once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (moving)
                    begin
                        enc_next[0] = encoder_left;
                        enc_next[1] = encoder_right;
                        tgt_next[0] = target_left;
                        tgt_next[1] = target_right;
                        ch_next     = 1'b1;
                        state_next  = ST_DIFF;
                    end
                    else if (last_speed_reg[0] != '0 || last_speed_reg[1] != '0)
                    begin
                        // Stopped: rebase counts and clear both controllers
                        last_count_next[0] = encoder_left;
                        last_count_next[1] = encoder_right;
                        for (int i = 0; i < 2; i++)
                        begin
                            last_speed_next[i] = '0;
                            last_drive_next[i] = '0;
                            integ_next[i]      = '0;
                        end
                    end
                end
            end
            ST_DIFF:
            begin
                speed_next = $signed(enc_reg[ch_reg] - last_count_reg[ch_reg]);
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                err_next   = ERR_W'(tgt_reg[ch_reg]) - ERR_W'(speed_reg);
                dsp_next   = ERR_W'(speed_reg) - ERR_W'(last_speed_reg[ch_reg]);
                state_next = ST_MULP;
            end
            ST_MULP:
            begin
                prod_next  = mul_res;
                acc_next   = ACC_W'(integ_reg[ch_reg]);
                state_next = ST_MULD;
            end
            ST_MULD:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                prod_next  = mul_res;
                state_next = ST_MULI;
            end
            ST_MULI:
            begin
                acc_next   = acc_reg - ACC_W'(prod_reg);
                prod_next  = mul_res;
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                // Divide |num| >> 8 by the divisor; sign restored afterwards
                neg_next   = acc_reg[ACC_W-1];
                dq_next    = mag[ACC_W-1:8];
                rem_next   = '0;
                dvs_next   = (divisor_reg == '0) ? 16'd1 : divisor_reg;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = step_lo[15:0];
                dq_next   = {dq_reg[QUO_W-3:0], step_hi[16], step_lo[16]};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                acc_next   = qsig + ACC_W'(last_drive_reg[ch_reg]);
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                // Clamp the drive; grow the integral only when unclamped
                if (!clamped)
                begin
                    if (!isum[INTEG_W+2] && (isum[INTEG_W+1:INTEG_W-1] != '0))
                        integ_next[ch_reg] = {1'b0, {(INTEG_W-1){1'b1}}};
                    else if (isum[INTEG_W+2] && (isum[INTEG_W+1:INTEG_W-1] != '1))
                        integ_next[ch_reg] = {1'b1, {(INTEG_W-1){1'b0}}};
                    else
                        integ_next[ch_reg] = isum[INTEG_W-1:0];
                end
                last_count_next[ch_reg] = enc_reg[ch_reg];
                last_speed_next[ch_reg] = speed_reg;
                last_drive_next[ch_reg] = drive_val;
                if (ch_reg)
                begin
                    ch_next    = 1'b0;
                    state_next = ST_DIFF;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    drive_left_next  = last_drive_reg[0];
                    drive_right_next = last_drive_reg[1];
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            divisor_reg   <= DIVISOR_RST;
            max_pwm_reg   <= MAX_PWM_RST;
            for (int i = 0; i < 2; i++)
            begin
                last_count_reg[i] <= '0;
                last_speed_reg[i] <= '0;
                last_drive_reg[i] <= '0;
                integ_reg[i]      <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
            last_count_reg <= last_count_next;
            last_speed_reg <= last_speed_next;
            last_drive_reg <= last_drive_next;
            integ_reg      <= integ_next;
            // Take a configuration beat
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GAIN_P:  gain_p_reg  <= cfg_data;
                    CFG_GAIN_I:  gain_i_reg  <= cfg_data;
                    CFG_GAIN_D:  gain_d_reg  <= cfg_data;
                    CFG_DIVISOR: divisor_reg <= cfg_data;
                    CFG_MAX_PWM: max_pwm_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        enc_reg         <= enc_next;
        tgt_reg         <= tgt_next;
        speed_reg       <= speed_next;
        err_reg         <= err_next;
        dsp_reg         <= dsp_next;
        prod_reg        <= prod_next;
        acc_reg         <= acc_next;
        neg_reg         <= neg_next;
        dq_reg          <= dq_next;
        rem_reg         <= rem_next;
        dvs_reg         <= dvs_next;
        drive_left_reg  <= drive_left_next;
        drive_right_reg <= drive_right_next;
    end

    // Checks
    `ASSERT_PROP(a_rem_below_divisor, clk, rst_n, (state_reg == ST_DIV) |-> (rem_reg < dvs_reg))
    `ASSERT_PROP(a_right_then_left, clk, rst_n, (state_reg == ST_CLAMP && ch_reg) |=> (state_reg == ST_DIFF && !ch_reg))
    `ASSERT_PROP(a_result_from_done, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
    `ASSERT_NEVER(a_div_count_range, clk, rst_n, (state_reg == ST_DIV) && (dcnt_reg > DCNT_W'(DIV_STEPS - 1)))

endmodule
